// ----- rtl/css420_pkg.sv -----
package css420_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int PAIR_W     = 9;
    localparam int CFG_W      = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int ROW_W      = 12;

    localparam int HEIGHT_LIMIT           = 4096;
    localparam int LINE_WIDTH_RESET       = 3840;
    localparam int FRAME_HEIGHT_RESET     = 2160;
    localparam int MAX_LINE_WIDTH_DEFAULT = 4096;
    localparam int QUEUE_DEPTH_DEFAULT    = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = CFG_ADDR_W'(1);

    // one command from the front part to the back part
    typedef struct packed {
        logic              emit;       // 1: read the line store and emit, 0: write it
        logic              row_end;
        logic              frame_end;
        logic [PAIR_W-1:0] pair_sum;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

endpackage

// ----- rtl/css420_front.sv -----
module css420_front
    import css420_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEFAULT,
    parameter int SLOT_W         = $clog2(MAX_LINE_WIDTH / 2)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_cmd,
    output logic [SLOT_W-1:0]     o_slot
);

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int WW    = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CW    = (WW > CFG_W) ? WW : CFG_W;

    // round down to even, clamp to 2 .. limit
    function automatic logic [COL_W-1:0] f_last_col(input logic [CFG_W-1:0] raw);
        logic [CW-1:0] v;
        logic [CW-1:0] lim;
        v   = CW'(raw) & ~CW'(1);
        lim = CW'(MAX_LINE_WIDTH) & ~CW'(1);
        if (v < CW'(2)) v = CW'(2);
        if (v > lim) v = lim;
        return COL_W'(v - CW'(1));
    endfunction

    function automatic logic [ROW_W-1:0] f_last_row(input logic [CFG_W-1:0] raw);
        logic [CFG_W-1:0] v;
        v = raw & ~CFG_W'(1);
        if (v < CFG_W'(2)) v = CFG_W'(2);
        if (v > CFG_W'(HEIGHT_LIMIT)) v = CFG_W'(HEIGHT_LIMIT);
        return ROW_W'(v - CFG_W'(1));
    endfunction

    logic [COL_W-1:0]    r_last_col;
    logic [ROW_W-1:0]    r_last_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [SAMPLE_W-1:0] r_held;

    logic accept;
    logic last_col;
    logic last_row;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign last_col   = r_col >= r_last_col;
    assign last_row   = r_row >= r_last_row;

    // even column: hold only; odd column on even row: store; odd on odd row: emit
    assign o_q_push        = accept && r_col[0];
    assign o_cmd.emit      = r_row[0];
    assign o_cmd.row_end   = last_col;
    assign o_cmd.frame_end = last_col && last_row;
    assign o_cmd.pair_sum  = PAIR_W'(r_held) + PAIR_W'(i_sample);
    assign o_slot          = SLOT_W'(r_col >> 1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= f_last_col(CFG_W'(LINE_WIDTH_RESET));
            r_last_row <= f_last_row(CFG_W'(FRAME_HEIGHT_RESET));
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LINE_WIDTH:   r_last_col <= f_last_col(i_cfg_data);
                    REG_FRAME_HEIGHT: r_last_row <= f_last_row(i_cfg_data);
                    default: ;
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                if (!r_col[0]) r_held <= i_sample;
            end
        end
    end

endmodule

// ----- rtl/css420_queue.sv -----
module css420_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/css420_back.sv -----
module css420_back
    import css420_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEFAULT,
    parameter int SLOT_W         = $clog2(MAX_LINE_WIDTH / 2)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_cmd,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_q_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [SAMPLE_W-1:0] o_average,
    output logic                o_row_end,
    output logic                o_frame_end
);

    localparam int LINE_DEPTH = MAX_LINE_WIDTH / 2;

    logic [PAIR_W-1:0] r_line [LINE_DEPTH];

    logic              r_a_valid;
    logic [PAIR_W-1:0] r_a_above;
    logic [PAIR_W-1:0] r_a_pair;
    logic              r_a_row_end;
    logic              r_a_frame_end;

    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_avg;
    logic                r_o_row_end;
    logic                r_o_frame_end;

    logic              out_ready;
    logic              a_load;
    logic [PAIR_W:0]   block_sum;

    assign out_ready = !r_o_valid || i_m_tready;
    assign a_load    = !r_a_valid || out_ready;
    assign o_q_pop   = i_q_valid && a_load;
    assign block_sum = {1'b0, r_a_above} + {1'b0, r_a_pair};

    // line store: write pair sums on even rows, read them back on odd rows
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_cmd.emit) r_a_above <= r_line[i_slot];
            else            r_line[i_slot] <= i_cmd.pair_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_pair      <= i_cmd.pair_sum;
            r_a_row_end   <= i_cmd.row_end;
            r_a_frame_end <= i_cmd.frame_end;
        end
        if (out_ready) begin
            r_o_avg       <= block_sum[PAIR_W:2];
            r_o_row_end   <= r_a_row_end;
            r_o_frame_end <= r_a_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_load)    r_a_valid <= o_q_pop && i_cmd.emit;
            if (out_ready) r_o_valid <= r_a_valid;
        end
    end

    assign o_m_tvalid  = r_o_valid;
    assign o_average   = r_o_avg;
    assign o_row_end   = r_o_row_end;
    assign o_frame_end = r_o_frame_end;

endmodule

// ----- rtl/chroma_subsample_420_unit.sv -----
// 4:4:4 to 4:2:0 chroma subsampler, 2x2 box average.
// Input stream: one 8-bit chroma sample per item in raster order, no tlast/tuser.
// Output stream: one item per 2x2 block, emitted on the second sample of each
// odd-row pair; tdata carries the truncated block mean, tlast marks the last
// item of a subsampled row and tuser[0] the last item of the frame.
// Configuration: i_cfg_we writes register i_cfg_addr (0 line width, 1 frame
// height); odd values round down, values clamp to 2 .. limit. Write while idle.
// Throughput: one sample per cycle while the receiver keeps up. The front part
// steps the column/row counters and pushes one command per pair into a
// QUEUE_DEPTH-entry queue (4 by default); the back part reads or writes the
// line store (one port per cycle) and registers the result.
// Path: an odd-row second sample enters the queue, then the stage-A register
// with the line-store read, then the output register that drives o_m_tvalid.
// Reset clears counters, queue and output valid; registers return to 3840 x 2160.
// The line store is not cleared; the first frame writes every entry it reads.
// When the receiver stalls the output register holds; the queue absorbs a few
// pairs, then o_s_tready drops until the receiver takes items again.
module chroma_subsample_420_unit
    import css420_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] chroma_sample
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [7:0] block_average
    output logic                  o_m_tlast,   // row_end
    output logic [0:0]            o_m_tuser    // [0] frame_end
);

    localparam int SLOT_W = $clog2(MAX_LINE_WIDTH / 2);
    localparam int Q_W    = CMD_W + SLOT_W;

    t_cmd              f_cmd, b_cmd;
    logic [SLOT_W-1:0] f_slot, b_slot;
    logic              q_push, q_full, q_pop, q_valid;
    logic [Q_W-1:0]    q_out;
    logic              frame_end;

    css420_front #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
        .SLOT_W        (SLOT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sample  (i_s_tdata),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_cmd     (f_cmd),
        .o_slot    (f_slot)
    );

    css420_queue #(
        .DATA_W(Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data ({f_slot, f_cmd}),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    assign b_cmd  = t_cmd'(q_out[CMD_W-1:0]);
    assign b_slot = q_out[Q_W-1:CMD_W];

    css420_back #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
        .SLOT_W        (SLOT_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_cmd      (b_cmd),
        .i_slot     (b_slot),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_average  (o_m_tdata),
        .o_row_end  (o_m_tlast),
        .o_frame_end(frame_end)
    );

    assign o_m_tuser = frame_end;

endmodule

// ----- rtl/css420_checker.sv -----
module css420_checker
    import css420_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic [0:0] o_m_tuser
);

    // a frame always ends on a row end
    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("frame end without row end");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // nothing comes out in the first cycle after reset: no item can reach the output
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_m_tvalid)
        else $error("result too soon after reset");

endmodule

bind chroma_subsample_420_unit css420_checker u_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import css420_pkg::*;

    localparam int LINE_DEPTH  = MAX_LINE_WIDTH_DEFAULT / 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                row_end;
        logic                frame_end;
    } t_block;

    // Predicts 2x2 block averages from accepted samples and checks the output stream.
    class block_scoreboard;
        logic [CFG_W-1:0]    width_reg = CFG_W'(LINE_WIDTH_RESET);
        logic [CFG_W-1:0]    height_reg = CFG_W'(FRAME_HEIGHT_RESET);
        logic [ROW_W-1:0]    col = '0;
        logic [ROW_W-1:0]    row = '0;
        logic [SAMPLE_W-1:0] held = '0;
        logic [PAIR_W-1:0]   pair_line [LINE_DEPTH];
        t_block              expected_blocks [$];
        int unsigned         errors = 0;
        int unsigned         blocks_checked = 0;

        function int unsigned usable(int unsigned raw, int unsigned limit);
            int unsigned v;
            v = raw & ~1;
            if (v < 2) v = 2;
            if (v > limit) v = limit & ~1;
            return v;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
            if (addr == REG_LINE_WIDTH) width_reg = value;
            else if (addr == REG_FRAME_HEIGHT) height_reg = value;
        endfunction

        function int unsigned pending();
            return expected_blocks.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            int unsigned   w;
            int unsigned   h;
            int unsigned   slot;
            bit            last_col;
            bit            last_row;
            logic [9:0]    sum;
            t_block        blk;
            w = usable(32'(width_reg), MAX_LINE_WIDTH_DEFAULT);
            h = usable(32'(height_reg), HEIGHT_LIMIT);
            slot = (32'(col) >> 1) % LINE_DEPTH;
            last_col = 32'(col) >= w - 1;
            last_row = 32'(row) >= h - 1;
            if (!col[0]) begin
                held = s;
            end else if (!row[0]) begin
                pair_line[slot] = PAIR_W'(held) + PAIR_W'(s);
            end else begin
                sum = 10'(pair_line[slot]) + 10'(held) + 10'(s);
                blk.average = sum[9:2];
                blk.row_end = last_col;
                blk.frame_end = last_col && last_row;
                expected_blocks.push_back(blk);
            end
            if (last_col) begin
                col = '0;
                row = last_row ? '0 : row + ROW_W'(1);
            end else begin
                col = col + ROW_W'(1);
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_block(logic [7:0] avg, logic last, logic fend);
            t_block want;
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("unexpected item avg=%0d last=%0b frame_end=%0b",
                                          avg, last, fend));
                return;
            end
            want = expected_blocks.pop_front();
            blocks_checked++;
            if (avg !== want.average)
                report_mismatch($sformatf("block %0d average got %0d want %0d",
                                          blocks_checked, avg, want.average));
            if (last !== want.row_end)
                report_mismatch($sformatf("block %0d row_end got %0b want %0b",
                                          blocks_checked, last, want.row_end));
            if (fend !== want.frame_end)
                report_mismatch($sformatf("block %0d frame_end got %0b want %0b",
                                          blocks_checked, fend, want.frame_end));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;   // [7:0] chroma_sample
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [7:0]            o_m_tdata;   // [7:0] block_average
    logic                  o_m_tlast;   // row_end
    logic [0:0]            o_m_tuser;   // [0] frame_end

    block_scoreboard sb;
    int unsigned     src_idle_pct;
    int unsigned     sink_idle_pct;
    int unsigned     cycle_count;
    int unsigned     samples_sent;
    int unsigned     frames_run;
    int unsigned     shrinks_done;

    chroma_subsample_420_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Check the output item taken at this edge, then pick the next ready.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready)
            sb.check_block(o_m_tdata, o_m_tlast, o_m_tuser[0]);
        i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task send_sample(input logic [7:0] s);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= s;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(s);
        samples_sent++;
    endtask

    // Drop valid, drain every pending block, then let queued line writes finish.
    task wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task write_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(addr, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [7:0] pick_sample(int unsigned pattern);
        case (pattern)
            1: return 8'hFF;
            2: return 8'h00;
            3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Run one frame from the top-left corner until the position wraps.
    // Optionally shrink a size mid-frame; growing only happens between frames
    // so that no line entry is read before it is written.
    task run_frame(input logic [CFG_W-1:0] wraw, input logic [CFG_W-1:0] hraw,
                   input int unsigned pattern, input bit allow_shrink);
        int unsigned n;
        int unsigned shrink_at;
        int unsigned k;
        wait_idle();
        write_cfg(REG_LINE_WIDTH, wraw);
        write_cfg(REG_FRAME_HEIGHT, hraw);
        n = sb.usable(32'(wraw), MAX_LINE_WIDTH_DEFAULT) * sb.usable(32'(hraw), HEIGHT_LIMIT);
        shrink_at = (allow_shrink && n > 2) ? $urandom_range(1, n - 1) : n + 1;
        k = 0;
        do begin
            if (k == shrink_at) begin
                wait_idle();
                if ($urandom_range(0, 1))
                    write_cfg(REG_LINE_WIDTH,
                              CFG_W'($urandom_range(0, 32'(sb.width_reg))));
                else
                    write_cfg(REG_FRAME_HEIGHT,
                              CFG_W'($urandom_range(0, 32'(sb.height_reg))));
                shrinks_done++;
            end else if ($urandom_range(0, 63) == 0) begin
                wait_idle();
            end
            send_sample(pick_sample(pattern));
            k++;
        end while (!(sb.col == 0 && sb.row == 0));
        frames_run++;
    endtask

    initial begin
        int unsigned        phase_start;
        logic [CFG_W-1:0]   wraw;
        logic [CFG_W-1:0]   hraw;
        sb = new();
        samples_sent = 0;
        frames_run = 0;
        shrinks_done = 0;
        src_idle_pct = 22;
        sink_idle_pct = 82;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= REG_LINE_WIDTH;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Odd width rounds down to 4, zero height is raised to 2.
        write_cfg(REG_LINE_WIDTH, CFG_W'(5));
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(0));
        send_sample(8'hFF); send_sample(8'hFF); send_sample(8'h00); send_sample(8'h00);
        send_sample(8'hFF); send_sample(8'hFF); send_sample(8'h00); send_sample(8'h03);
        frames_run++;

        // 8x4 frame, shrunk mid-frame: row 1 ends on an even column, row 2 ends it.
        wait_idle();
        write_cfg(REG_LINE_WIDTH, CFG_W'(8));
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(4));
        repeat (12) send_sample(pick_sample(0));
        wait_idle();
        write_cfg(REG_LINE_WIDTH, CFG_W'(4));
        send_sample(8'hA5);
        wait_idle();
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(2));
        repeat (4) send_sample(pick_sample(0));
        frames_run++;
        shrinks_done += 2;

        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            src_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 82 : 0;
            sink_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 22 : 0;
            phase_start = samples_sent;
            while (samples_sent - phase_start < 580) begin
                wraw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(26, 64))
                                                   : CFG_W'($urandom_range(0, 24));
                hraw = CFG_W'($urandom_range(0, 8));
                run_frame(wraw, hraw, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                          $urandom_range(0, 4) == 0);
            end
        end

        // Largest sizes, cut short by shrinks so the frames stay small.
        wait_idle();
        write_cfg(REG_LINE_WIDTH, CFG_W'(8191));
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(8191));
        repeat (40) send_sample(pick_sample(0));
        wait_idle();
        write_cfg(REG_LINE_WIDTH, CFG_W'(6));
        repeat (7) send_sample(pick_sample(1));
        wait_idle();
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(2));
        repeat (6) send_sample(pick_sample(0));
        frames_run++;
        shrinks_done += 2;

        wait_idle();
        write_cfg(REG_LINE_WIDTH, CFG_W'(0));
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(4097));
        repeat (18) send_sample(pick_sample(0));
        wait_idle();
        write_cfg(REG_FRAME_HEIGHT, CFG_W'(4));
        repeat (2) send_sample(pick_sample(0));
        frames_run++;
        shrinks_done++;

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d samples in %0d frames, checked %0d block averages",
                 samples_sent, frames_run, sb.blocks_checked);
        $display("Small frames under three stall mixes, %0d mid-frame shrinks, clamped sizes",
                 shrinks_done);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d blocks still expected", sb.errors, sb.pending());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
